@@ hdl/obtip_pkg.sv @@
// Package for the one-bone tip solver: the payload records that travel
// down the cell chains. No dependencies.
package obtip_pkg;

   localparam int unsigned NORM_CELLS = 5;
   localparam int unsigned SQRT_CELLS = 32;
   localparam int unsigned DIV_CELLS  = 31;

   // Data that rides along unchanged from the front to the output stage.
   typedef struct packed {
      logic [2:0][31:0] base;
      logic [2:0]       neg;
      logic             zero;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [30:0]      blen;
      logic [30:0]      m;
      logic [2:0][30:0] mag;
   } norm_type;

   typedef struct packed {
      side_type         side;
      logic [2:0][61:0] prod;
      logic [63:0]      rad;
      logic [33:0]      rem;
      logic [31:0]      root;
   } sqrt_type;

   typedef struct packed {
      side_type         side;
      logic [31:0]      len;
      logic [2:0][62:0] rem;
      logic [2:0][30:0] quo;
   } div_type;

endpackage

@@ hdl/obtip_norm_cell.sv @@
// One normalize cell: conditional left shift of the magnitudes by SHIFT.
// Depends on obtip_pkg.
module obtip_norm_cell import obtip_pkg::*; #(
   parameter int unsigned SHIFT = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  norm_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output norm_type out_data
);

   logic     valid_ff;
   norm_type data_ff;
   norm_type data_in;

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = in_data;
      // shift when the top SHIFT bits of the max are clear
      if (in_data.m[30 -: SHIFT] == '0) begin
         data_in.m = in_data.m << SHIFT;
         for (int i = 0; i < 3; i++) begin
            data_in.mag[i] = in_data.mag[i] << SHIFT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ hdl/obtip_sqrt_cell.sv @@
// One square root cell: resolves one root bit from two radicand bits.
// Depends on obtip_pkg.
module obtip_sqrt_cell import obtip_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  sqrt_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output sqrt_type out_data
);

   logic     valid_ff;
   sqrt_type data_ff;
   sqrt_type data_in;
   logic [33:0] rem2;
   logic [33:0] trial;

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      rem2    = {in_data.rem[31:0], in_data.rad[63:62]};
      trial   = {in_data.root, 2'b01};
      data_in = in_data;
      data_in.rad = {in_data.rad[61:0], 2'b00};
      if (rem2 >= trial) begin
         data_in.rem  = rem2 - trial;
         data_in.root = {in_data.root[30:0], 1'b1};
      end else begin
         data_in.rem  = rem2;
         data_in.root = {in_data.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ hdl/obtip_div_cell.sv @@
// One divider cell: resolves quotient bit SHIFT for all three lanes.
// Depends on obtip_pkg.
module obtip_div_cell import obtip_pkg::*; #(
   parameter int unsigned SHIFT = 30
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic        valid_ff;
   div_type     data_ff;
   div_type     data_in;
   logic [62:0] dvs;

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign dvs       = {31'b0, in_data.len} << SHIFT;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < 3; i++) begin
         if (in_data.rem[i] >= dvs) begin
            data_in.rem[i] = in_data.rem[i] - dvs;
            data_in.quo[i] = {in_data.quo[i][29:0], 1'b1};
         end else begin
            data_in.quo[i] = {in_data.quo[i][29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ hdl/one_bone_ik_tip_solve.sv @@
// Structure: 74 register stages, set mostly by the 32-cell square root chain
// and the 31-cell divider chain.
// Throughput: one request per cycle; every stage holds its own valid bit, so
// bubbles collapse and a stalled result blocks the front only once all stages fill.
// Reset: synchronous, active high; clears all stage valid bits.
module one_bone_ik_tip_solve import obtip_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_base_x,
   input  logic signed [31:0] req_base_y,
   input  logic signed [31:0] req_base_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic        [30:0] req_bone_length,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_tip_x,
   output logic signed [31:0] rsp_tip_y,
   output logic signed [31:0] rsp_tip_z,
   output logic               rsp_zero_direction
);

   // ---------------------------------------------------------------
   // Stage 1: capture base and the 33-bit direction target - base.
   // ---------------------------------------------------------------
   logic             s1_valid_ff;
   logic             s1_ready;
   logic [2:0][31:0] s1_base_ff;
   logic [2:0][32:0] s1_diff_ff;
   logic [30:0]      s1_blen_ff;

   logic             s2_valid_ff;
   logic             s2_ready;
   norm_type         s2_data_ff;
   norm_type         s2_data_in;

   assign s1_ready  = ~s1_valid_ff | s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_base_ff[0] <= req_base_x;
         s1_base_ff[1] <= req_base_y;
         s1_base_ff[2] <= req_base_z;
         s1_diff_ff[0] <= {req_target_x[31], req_target_x} - {req_base_x[31], req_base_x};
         s1_diff_ff[1] <= {req_target_y[31], req_target_y} - {req_base_y[31], req_base_y};
         s1_diff_ff[2] <= {req_target_z[31], req_target_z} - {req_base_z[31], req_base_z};
         s1_blen_ff    <= req_bone_length;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: magnitudes, their maximum, and the coarse right shift
   // that brings the maximum below 2^31.
   // ---------------------------------------------------------------
   logic [2:0][32:0] abs_val;
   logic [32:0]      max_val;

   always_comb begin
      max_val    = '0;
      s2_data_in = '0;
      for (int i = 0; i < 3; i++) begin
         abs_val[i] = s1_diff_ff[i][32] ? (33'd0 - s1_diff_ff[i]) : s1_diff_ff[i];
         s2_data_in.side.neg[i] = s1_diff_ff[i][32];
      end
      for (int i = 0; i < 3; i++) begin
         if (abs_val[i] > max_val) begin
            max_val = abs_val[i];
         end
      end
      s2_data_in.side.base = s1_base_ff;
      s2_data_in.side.zero = (max_val == '0);
      s2_data_in.blen      = s1_blen_ff;
      priority if (max_val[32]) begin
         s2_data_in.m = max_val[32:2];
         for (int i = 0; i < 3; i++) begin
            s2_data_in.mag[i] = abs_val[i][32:2];
         end
      end else if (max_val[31]) begin
         s2_data_in.m = max_val[31:1];
         for (int i = 0; i < 3; i++) begin
            s2_data_in.mag[i] = abs_val[i][31:1];
         end
      end else begin
         s2_data_in.m = max_val[30:0];
         for (int i = 0; i < 3; i++) begin
            s2_data_in.mag[i] = abs_val[i][30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_data_ff <= s2_data_in;
      end
   end

   // ---------------------------------------------------------------
   // Normalize chain: shifts of 16, 8, 4, 2, 1 put the max in
   // [2^30, 2^31) for any nonzero direction.
   // ---------------------------------------------------------------
   norm_type norm_d [NORM_CELLS+1];
   logic     norm_v [NORM_CELLS+1];
   logic     norm_r [NORM_CELLS+1];

   assign norm_d[0] = s2_data_ff;
   assign norm_v[0] = s2_valid_ff;
   assign s2_ready  = ~s2_valid_ff | norm_r[0];

   for (genvar g = 0; g < NORM_CELLS; g++) begin : g_norm
      obtip_norm_cell #(
         .SHIFT (16 >> g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (norm_v[g]),
         .in_ready  (norm_r[g]),
         .in_data   (norm_d[g]),
         .out_valid (norm_v[g+1]),
         .out_ready (norm_r[g+1]),
         .out_data  (norm_d[g+1])
      );
   end

   // ---------------------------------------------------------------
   // Stage 3: squares and length products, one multiplier each.
   // ---------------------------------------------------------------
   logic             s3_valid_ff;
   logic             s3_ready;
   side_type         s3_side_ff;
   logic [2:0][61:0] s3_sq_ff;
   logic [2:0][61:0] s3_prod_ff;

   logic             s4_ready;

   assign s3_ready                 = ~s3_valid_ff | s4_ready;
   assign norm_r[NORM_CELLS]       = s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= norm_v[NORM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (norm_v[NORM_CELLS] && s3_ready) begin
         s3_side_ff <= norm_d[NORM_CELLS].side;
         for (int i = 0; i < 3; i++) begin
            s3_sq_ff[i]   <= norm_d[NORM_CELLS].mag[i] * norm_d[NORM_CELLS].mag[i];
            s3_prod_ff[i] <= norm_d[NORM_CELLS].mag[i] * norm_d[NORM_CELLS].blen;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: sum of squares seeds the square root chain.
   // ---------------------------------------------------------------
   logic     s4_valid_ff;
   sqrt_type s4_data_ff;
   sqrt_type s4_data_in;

   sqrt_type sqrt_d [SQRT_CELLS+1];
   logic     sqrt_v [SQRT_CELLS+1];
   logic     sqrt_r [SQRT_CELLS+1];

   assign s4_ready = ~s4_valid_ff | sqrt_r[0];

   always_comb begin
      s4_data_in      = '0;
      s4_data_in.side = s3_side_ff;
      s4_data_in.prod = s3_prod_ff;
      s4_data_in.rad  = {2'b00, s3_sq_ff[0]} + {2'b00, s3_sq_ff[1]} + {2'b00, s3_sq_ff[2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && s4_ready) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign sqrt_d[0] = s4_data_ff;
   assign sqrt_v[0] = s4_valid_ff;

   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      obtip_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sqrt_v[g]),
         .in_ready  (sqrt_r[g]),
         .in_data   (sqrt_d[g]),
         .out_valid (sqrt_v[g+1]),
         .out_ready (sqrt_r[g+1]),
         .out_data  (sqrt_d[g+1])
      );
   end

   // ---------------------------------------------------------------
   // Stage 5: add half the length for round half up, seed the divider.
   // ---------------------------------------------------------------
   logic     s5_valid_ff;
   logic     s5_ready;
   div_type  s5_data_ff;
   div_type  s5_data_in;
   logic [31:0] len_val;

   div_type  div_d [DIV_CELLS+1];
   logic     div_v [DIV_CELLS+1];
   logic     div_r [DIV_CELLS+1];

   assign s5_ready               = ~s5_valid_ff | div_r[0];
   assign sqrt_r[SQRT_CELLS]     = s5_ready;

   always_comb begin
      len_val = (sqrt_d[SQRT_CELLS].root == '0) ? 32'd1 : sqrt_d[SQRT_CELLS].root;
      s5_data_in      = '0;
      s5_data_in.side = sqrt_d[SQRT_CELLS].side;
      s5_data_in.len  = len_val;
      for (int i = 0; i < 3; i++) begin
         s5_data_in.rem[i] = {1'b0, sqrt_d[SQRT_CELLS].prod[i]} + {32'b0, len_val[31:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_ready) begin
         s5_valid_ff <= sqrt_v[SQRT_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (sqrt_v[SQRT_CELLS] && s5_ready) begin
         s5_data_ff <= s5_data_in;
      end
   end

   assign div_d[0] = s5_data_ff;
   assign div_v[0] = s5_valid_ff;

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      obtip_div_cell #(
         .SHIFT (30 - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_v[g]),
         .in_ready  (div_r[g]),
         .in_data   (div_d[g]),
         .out_valid (div_v[g+1]),
         .out_ready (div_r[g+1]),
         .out_data  (div_d[g+1])
      );
   end

   // ---------------------------------------------------------------
   // Output stage: apply sign, add base, saturate (base alone for a zero direction); hold for rsp_ready.
   // ---------------------------------------------------------------
   logic             rsp_valid_ff;
   logic             out_ready;
   logic [2:0][31:0] tip_ff;
   logic [2:0][31:0] tip_in;
   logic             zero_ff;
   logic [2:0][33:0] off_val;
   logic [2:0][33:0] sum_val;
   side_type         fin_side;

   assign out_ready            = ~rsp_valid_ff | rsp_ready;
   assign div_r[DIV_CELLS]     = out_ready;
   assign fin_side             = div_d[DIV_CELLS].side;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off_val[i] = fin_side.neg[i] ? (34'd0 - {3'b000, div_d[DIV_CELLS].quo[i]})
                                      : {3'b000, div_d[DIV_CELLS].quo[i]};
         sum_val[i] = {{2{fin_side.base[i][31]}}, fin_side.base[i]} + off_val[i];
         priority if (fin_side.zero) begin
            tip_in[i] = fin_side.base[i];
         end else if (!sum_val[i][33] && sum_val[i][32:31] != 2'b00) begin
            tip_in[i] = 32'h7FFF_FFFF;
         end else if (sum_val[i][33] && sum_val[i][32:31] != 2'b11) begin
            tip_in[i] = 32'h8000_0000;
         end else begin
            tip_in[i] = sum_val[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_v[DIV_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (div_v[DIV_CELLS] && out_ready) begin
         tip_ff  <= tip_in;
         zero_ff <= fin_side.zero;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tip_x          = tip_ff[0];
   assign rsp_tip_y          = tip_ff[1];
   assign rsp_tip_z          = tip_ff[2];
   assign rsp_zero_direction = zero_ff;

`ifndef SYNTHESIS
   // A nonzero direction leaves normalization with the max in its top bit.
   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      norm_v[NORM_CELLS] && !norm_d[NORM_CELLS].side.zero |-> norm_d[NORM_CELLS].m[30])
      else $error("normalized max below 2^30");

   // Root of a normalized sum is at least 2^30.
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      sqrt_v[SQRT_CELLS] && !sqrt_d[SQRT_CELLS].side.zero
      |-> sqrt_d[SQRT_CELLS].root[31:30] != 2'b00)
      else $error("square root result out of range");

   // Remainder after the last divider cell is below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      div_v[DIV_CELLS] |-> div_d[DIV_CELLS].rem[0] < {31'b0, div_d[DIV_CELLS].len}
                        && div_d[DIV_CELLS].rem[1] < {31'b0, div_d[DIV_CELLS].len}
                        && div_d[DIV_CELLS].rem[2] < {31'b0, div_d[DIV_CELLS].len})
      else $error("divider remainder not reduced");

   // A zero direction returns the base unchanged.
   a_zero_base: assert property (@(posedge clock) disable iff (reset)
      div_v[DIV_CELLS] && fin_side.zero |-> tip_in == fin_side.base)
      else $error("zero direction tip differs from base");
`endif

endmodule

@@ verif/one_bone_ik_tip_solve_tb.sv @@
// Testbench for one_bone_ik_tip_solve: directed and random chains checked
// against an internal tip predictor. Depends on obtip_pkg and the block RTL.
module one_bone_ik_tip_solve_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] x, y, z;
      logic               zero_dir;
   } tip_type;

   // Integer square root, floor, by the digit-pair method.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Place the tip on the ray toward the target at bone length from the base.
   function automatic tip_type solve_tip(input logic signed [31:0] b [3],
                                         input logic signed [31:0] t [3],
                                         input logic [30:0] blen);
      tip_type r;
      logic signed [33:0] d [3];
      logic [63:0] a [3];
      logic [63:0] m, sum, len, mag;
      logic signed [65:0] s;
      logic signed [31:0] tip [3];
      m = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = 34'(t[i]) - 34'(b[i]);
         a[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
         if (a[i] > m) m = a[i];
      end
      r.zero_dir = (m == 0);
      if (m == 0) begin
         for (int i = 0; i < 3; i++) tip[i] = b[i];
      end else begin
         if (m >= 64'd1 << 32) begin
            for (int i = 0; i < 3; i++) a[i] = a[i] >> 2;
         end else if (m >= 64'd1 << 31) begin
            for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
         end else begin
            while (m < 64'd1 << 30) begin
               m = m << 1;
               for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
            end
         end
         for (int i = 0; i < 3; i++) sum = sum + a[i] * a[i];
         len = floor_sqrt(sum);
         if (len == 0) len = 1;
         for (int i = 0; i < 3; i++) begin
            mag = (a[i] * 64'(blen) + (len >> 1)) / len;
            s = 66'(b[i]) + (d[i] < 0 ? -66'(mag) : 66'(mag));
            if (s > 66'sh7FFFFFFF) tip[i] = 32'h7FFFFFFF;
            else if (s < -66'sh80000000) tip[i] = 32'h80000000;
            else tip[i] = s[31:0];
         end
      end
      r.x = tip[0];
      r.y = tip[1];
      r.z = tip[2];
      return r;
   endfunction

   class tip_scoreboard;
      tip_type pending_tips[$];
      int errors = 0;

      function void note_request(input logic signed [31:0] b [3],
                                 input logic signed [31:0] t [3],
                                 input logic [30:0] blen);
         pending_tips.push_back(solve_tip(b, t, blen));
      endfunction

      function void check_tip(input tip_type got);
         tip_type want;
         if (pending_tips.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
            return;
         end
         want = pending_tips.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
             got.zero_dir !== want.zero_dir) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: want %h %h %h %b got %h %h %h %b",
                        want.x, want.y, want.z, want.zero_dir,
                        got.x, got.y, got.z, got.zero_dir);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, rsp_zero_direction;
   logic signed [31:0] req_base_x, req_base_y, req_base_z;
   logic signed [31:0] req_target_x, req_target_y, req_target_z;
   logic [30:0] req_bone_length;
   logic signed [31:0] rsp_tip_x, rsp_tip_y, rsp_tip_z;

   tip_scoreboard sb = new();
   bit stall_mode = 0;
   longint cycles = 0;

   one_bone_ik_tip_solve DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Abort the run if it hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stall the response side in a pattern: runs of steady ready, runs of
   // heavy backpressure, switched at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if ($urandom_range(0, 40) == 0) stall_mode <= ~stall_mode;
         rsp_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // Check every response at the edge where it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_tip({rsp_tip_x, rsp_tip_y, rsp_tip_z, rsp_zero_direction});
   end

   // Present one request and hold it until the block takes it.
   task automatic send_request(input logic signed [31:0] b [3],
                               input logic signed [31:0] t [3],
                               input logic [30:0] blen);
      req_valid <= 1;
      {req_base_x, req_base_y, req_base_z} <= {b[0], b[1], b[2]};
      {req_target_x, req_target_y, req_target_z} <= {t[0], t[1], t[2]};
      req_bone_length <= blen;
      do @(posedge clock); while (!req_ready);
      sb.note_request(b, t, blen);
   endtask

   // Drop valid for a random gap.
   task automatic idle_gap(input int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h80000000 + $urandom_range(0, 3);
         1: return 32'h7FFFFFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   logic signed [31:0] bv [3], tv [3];
   logic [30:0] lv;
   int burst;

   initial begin
      reset = 1;
      req_valid = 0;
      req_base_x = 0; req_base_y = 0; req_base_z = 0;
      req_target_x = 0; req_target_y = 0; req_target_z = 0;
      req_bone_length = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: target on base, zero length, extremes, saturation.
      for (int k = 0; k < 20; k++) begin
         for (int i = 0; i < 3; i++) begin
            bv[i] = 0;
            tv[i] = 0;
         end
         lv = 31'h10000;
         case (k)
            0: ;
            1: begin bv = '{32'h80000000, 32'h7FFFFFFF, 5}; tv = bv; end
            2: begin tv[0] = 32'h10000; lv = 0; end
            3: begin bv = '{32'h80000000, 32'h80000000, 32'h80000000};
                     tv = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
                     lv = 31'h7FFFFFFF; end
            4: begin tv = bv; bv = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
                     tv = '{32'h80000000, 32'h80000000, 32'h80000000};
                     lv = 31'h7FFFFFFF; end
            5: begin bv = '{32'h7FFFFFF0, 0, 0}; tv = '{32'h7FFFFFFF, 0, 0};
                     lv = 31'h7FFFFFFF; end
            6: begin bv = '{32'h80000010, 0, 0}; tv = '{32'h80000000, 0, 0};
                     lv = 31'h7FFFFFFF; end
            7: begin tv = '{1, 0, 0}; lv = 31'h7FFFFFFF; end
            8: begin tv = '{0, -1, 0}; lv = 1; end
            9: begin tv = '{0, 0, 1}; lv = 3; end
            10: begin tv = '{1, 1, 1}; lv = 31'h7FFFFFFF; end
            11: begin tv = '{32'h80000000, 0, 32'h7FFFFFFF}; end
            default: begin
               for (int i = 0; i < 3; i++) begin
                  bv[i] = rand_coord();
                  tv[i] = rand_coord();
               end
               lv = 31'($urandom);
            end
         endcase
         send_request(bv, tv, lv);
      end

      // Random bursts; most requests well formed, a few degenerate.
      for (int n = 0; n < 400; ) begin
         burst = $urandom_range(1, 30);
         for (int j = 0; j < burst; j++, n++) begin
            for (int i = 0; i < 3; i++) begin
               bv[i] = rand_coord();
               tv[i] = rand_coord();
            end
            if ($urandom_range(0, 15) == 0) tv = bv;
            case ($urandom_range(0, 4))
               0: lv = $urandom_range(0, 2) == 0 ? 31'h7FFFFFFF : 31'd0;
               1: lv = 31'($urandom_range(0, 65536 * 4));
               default: lv = 31'($urandom);
            endcase
            send_request(bv, tv, lv);
            if (n == 200) begin
               // Hold off until the pipe has fully drained.
               req_valid <= 0;
               while (sb.pending_tips.size() != 0) @(posedge clock);
            end
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
      req_valid <= 0;

      while (sb.pending_tips.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
